@@ rtl/ttt_pkg.sv @@
// Package with the shared constants, operation codes and control types of the taint tag table.
package ttt_pkg;

    localparam int INST_IDS     = 4096;
    localparam int ID_W         = $clog2(INST_IDS);
    localparam int ADDR_ENTRIES = 64;
    localparam int ENTRY_IDX_W  = $clog2(ADDR_ENTRIES);
    localparam int ADDR_W       = 64;
    localparam int OFF_W        = 32;
    localparam int MODE_W       = 4;

    localparam logic [ID_W-1:0] CLEAR_LAST = ID_W'(INST_IDS - 1);

    localparam logic [MODE_W-1:0] MODE_QINST    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_QADDR    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MARKINST = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MARKADDR = 4'd3;
    localparam logic [MODE_W-1:0] MODE_RMINST   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_RMADDR   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_R2R      = 4'd6;
    localparam logic [MODE_W-1:0] MODE_R2M      = 4'd7;
    localparam logic [MODE_W-1:0] MODE_M2R      = 4'd8;
    localparam logic [MODE_W-1:0] MODE_M2M      = 4'd9;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic                   set;
        logic                   clr;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [ADDR_W-1:0]      addr;
        logic [OFF_W-1:0]       off;
    } cam_wr_t;

    typedef struct packed {
        logic                   src_hit;
        logic [ENTRY_IDX_W-1:0] src_idx;
        logic                   dst_hit;
        logic [ENTRY_IDX_W-1:0] dst_idx;
        logic                   free_found;
        logic [ENTRY_IDX_W-1:0] free_idx;
    } cam_look_t;

endpackage

@@ rtl/ttt_bitmap.sv @@
// Single-bit instruction taint memory with one write port and one registered read port.
module ttt_bitmap (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ttt_pkg::ID_W-1:0] wr_addr,
    input  logic                     wr_data,
    input  logic                     rd_en,
    input  logic [ttt_pkg::ID_W-1:0] rd_addr,
    output logic                     rd_data
);

    logic mem [ttt_pkg::INST_IDS];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ttt_cam.sv @@
// Content-addressed table of tainted address and offset pairs with per-entry valid marks.
module ttt_cam (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ttt_pkg::cam_wr_t           wr,
    input  logic [ttt_pkg::ADDR_W-1:0] src_addr,
    input  logic [ttt_pkg::OFF_W-1:0]  src_off,
    input  logic [ttt_pkg::ADDR_W-1:0] dst_addr,
    input  logic [ttt_pkg::OFF_W-1:0]  dst_off,
    output ttt_pkg::cam_look_t         look
);

    logic [ttt_pkg::ADDR_ENTRIES-1:0] valid_reg;
    logic [ttt_pkg::ADDR_W-1:0]       addr_reg [ttt_pkg::ADDR_ENTRIES];
    logic [ttt_pkg::OFF_W-1:0]        off_reg  [ttt_pkg::ADDR_ENTRIES];
    logic [ttt_pkg::ADDR_ENTRIES-1:0] src_match;
    logic [ttt_pkg::ADDR_ENTRIES-1:0] dst_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.set)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
        else if (wr.clr)
        begin
            valid_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.set)
        begin
            addr_reg[wr.idx] <= wr.addr;
            off_reg[wr.idx]  <= wr.off;
        end
    end

    always_comb
    begin
        for (int i = 0; i < ttt_pkg::ADDR_ENTRIES; i++)
        begin
            src_match[i] = valid_reg[i] && (addr_reg[i] == src_addr) && (off_reg[i] == src_off);
            dst_match[i] = valid_reg[i] && (addr_reg[i] == dst_addr) && (off_reg[i] == dst_off);
        end
    end

    // Each encoder scans from the top so the lowest-numbered entry wins.
    always_comb
    begin
        look = '0;
        for (int i = ttt_pkg::ADDR_ENTRIES - 1; i >= 0; i--)
        begin
            if (src_match[i])
            begin
                look.src_hit = 1'b1;
                look.src_idx = ttt_pkg::ENTRY_IDX_W'(i);
            end
            if (dst_match[i])
            begin
                look.dst_hit = 1'b1;
                look.dst_idx = ttt_pkg::ENTRY_IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                look.free_found = 1'b1;
                look.free_idx   = ttt_pkg::ENTRY_IDX_W'(i);
            end
        end
    end

endmodule

@@ rtl/ttt_datapath.sv @@
// Datapath holding the transaction registers, both taint stores, the clear counter and the result register.
module ttt_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ttt_pkg::ctrl_cmd_t         cmd,
    output ttt_pkg::dp_status_t        status,
    input  logic [ttt_pkg::MODE_W-1:0] mode,
    input  logic [ttt_pkg::ID_W-1:0]   src_inst,
    input  logic [ttt_pkg::ID_W-1:0]   dst_inst,
    input  logic [ttt_pkg::ADDR_W-1:0] src_address,
    input  logic [ttt_pkg::OFF_W-1:0]  src_field_offset,
    input  logic [ttt_pkg::ADDR_W-1:0] dst_address,
    input  logic [ttt_pkg::OFF_W-1:0]  dst_field_offset,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic                       tainted,
    output logic                       overflow
);

    logic [ttt_pkg::MODE_W-1:0] mode_reg;
    logic [ttt_pkg::ID_W-1:0]   src_inst_reg;
    logic [ttt_pkg::ID_W-1:0]   dst_inst_reg;
    logic [ttt_pkg::ADDR_W-1:0] src_addr_reg;
    logic [ttt_pkg::OFF_W-1:0]  src_off_reg;
    logic [ttt_pkg::ADDR_W-1:0] dst_addr_reg;
    logic [ttt_pkg::OFF_W-1:0]  dst_off_reg;
    logic [ttt_pkg::ID_W-1:0]   clr_cnt_reg;
    logic [ttt_pkg::ID_W-1:0]   clr_cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       tainted_reg;
    logic                       overflow_reg;

    logic                       bm_rd_data;
    logic                       bm_wr_en;
    logic [ttt_pkg::ID_W-1:0]   bm_wr_addr;
    logic                       bm_wr_data;
    ttt_pkg::cam_wr_t           cam_wr;
    ttt_pkg::cam_look_t         look;

    logic                       taint;
    logic                       ovf;
    logic                       id_wr;
    logic [ttt_pkg::ID_W-1:0]   id_wr_addr;
    logic                       id_wr_val;
    logic                       do_mark;
    logic                       mark_dst;
    logic                       mark_hit;

    ttt_bitmap u_bitmap (
        .clk     (clk),
        .wr_en   (bm_wr_en),
        .wr_addr (bm_wr_addr),
        .wr_data (bm_wr_data),
        .rd_en   (cmd.load),
        .rd_addr (src_inst),
        .rd_data (bm_rd_data)
    );

    ttt_cam u_cam (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (cam_wr),
        .src_addr (src_addr_reg),
        .src_off  (src_off_reg),
        .dst_addr (dst_addr_reg),
        .dst_off  (dst_off_reg),
        .look     (look)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= mode;
            src_inst_reg <= src_inst;
            dst_inst_reg <= dst_inst;
            src_addr_reg <= src_address;
            src_off_reg  <= src_field_offset;
            dst_addr_reg <= dst_address;
            dst_off_reg  <= dst_field_offset;
        end
        if (cmd.exec)
        begin
            tainted_reg  <= taint;
            overflow_reg <= ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        taint      = 1'b0;
        id_wr      = 1'b0;
        id_wr_addr = src_inst_reg;
        id_wr_val  = 1'b0;
        do_mark    = 1'b0;
        mark_dst   = 1'b0;
        cam_wr     = '0;
        unique case (mode_reg)
            ttt_pkg::MODE_QINST:
            begin
                taint = bm_rd_data;
            end
            ttt_pkg::MODE_QADDR:
            begin
                taint = look.src_hit;
            end
            ttt_pkg::MODE_MARKINST:
            begin
                taint     = bm_rd_data;
                id_wr     = 1'b1;
                id_wr_val = 1'b1;
            end
            ttt_pkg::MODE_MARKADDR:
            begin
                taint   = look.src_hit;
                do_mark = 1'b1;
            end
            ttt_pkg::MODE_RMINST:
            begin
                taint = bm_rd_data;
                id_wr = 1'b1;
            end
            ttt_pkg::MODE_RMADDR:
            begin
                taint      = look.src_hit;
                cam_wr.clr = look.src_hit;
                cam_wr.idx = look.src_idx;
            end
            ttt_pkg::MODE_R2R:
            begin
                taint      = bm_rd_data;
                id_wr      = bm_rd_data;
                id_wr_addr = dst_inst_reg;
                id_wr_val  = 1'b1;
            end
            ttt_pkg::MODE_R2M:
            begin
                taint    = bm_rd_data;
                do_mark  = bm_rd_data;
                mark_dst = 1'b1;
            end
            ttt_pkg::MODE_M2R:
            begin
                taint      = look.src_hit;
                id_wr      = look.src_hit;
                id_wr_addr = dst_inst_reg;
                id_wr_val  = 1'b1;
            end
            ttt_pkg::MODE_M2M:
            begin
                taint      = look.src_hit;
                do_mark    = look.src_hit;
                mark_dst   = 1'b1;
                cam_wr.clr = !look.src_hit && look.dst_hit;
                cam_wr.idx = look.dst_idx;
            end
            default:
            begin
                taint = 1'b0;
            end
        endcase

        mark_hit = mark_dst ? look.dst_hit : look.src_hit;
        ovf      = do_mark && !mark_hit && !look.free_found;
        if (do_mark && !mark_hit && look.free_found)
        begin
            cam_wr.set  = 1'b1;
            cam_wr.idx  = look.free_idx;
            cam_wr.addr = mark_dst ? dst_addr_reg : src_addr_reg;
            cam_wr.off  = mark_dst ? dst_off_reg : src_off_reg;
        end
        if (!cmd.exec)
        begin
            cam_wr.set = 1'b0;
            cam_wr.clr = 1'b0;
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = clr_cnt_reg;
            bm_wr_data = 1'b0;
        end
        else
        begin
            bm_wr_en   = cmd.exec && id_wr;
            bm_wr_addr = id_wr_addr;
            bm_wr_data = id_wr_val;
        end
    end

    assign status.clear_last = (clr_cnt_reg == ttt_pkg::CLEAR_LAST);
    assign status.out_busy   = out_valid_reg && out_stall;
    assign out_valid         = out_valid_reg;
    assign tainted           = tainted_reg;
    assign overflow          = overflow_reg;

endmodule

@@ rtl/ttt_ctrl.sv @@
// Controller state machine that sequences the memory clear, transaction intake and execution.
module ttt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ttt_pkg::dp_status_t status,
    output ttt_pkg::ctrl_cmd_t  cmd
);

    ttt_pkg::state_t state_reg;
    ttt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttt_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ttt_pkg::ST_IDLE;
                end
            end
            ttt_pkg::ST_IDLE:
            begin
                if (in_valid && !status.out_busy)
                begin
                    state_next = ttt_pkg::ST_EXEC;
                end
            end
            ttt_pkg::ST_EXEC:
            begin
                state_next = ttt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ttt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ttt_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ttt_pkg::ST_IDLE:
            begin
                in_stall = status.out_busy;
                cmd.load = in_valid && !status.out_busy;
            end
            ttt_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/taint_tag_table_unit.sv @@
// Top level of the taint tag table: controller and datapath.
//
//  Channel  Handshake           Payload
//  input    in_valid/in_stall   mode, src_inst, dst_inst, src_address, src_field_offset,
//                               dst_address, dst_field_offset
//  output   out_valid/out_stall tainted, overflow
//
// Each transaction is captured, with the instruction bitmap read, in the idle state; the
// execute state then compares the pair table and writes the store that its mode names.
// After reset all 4096 ids of the bitmap are cleared, one id per cycle, with in_stall high.
// A new transaction is taken while the previous result waits, unless the output is stalled.
module taint_tag_table_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ttt_pkg::MODE_W-1:0] mode,
    input  logic [ttt_pkg::ID_W-1:0]   src_inst,
    input  logic [ttt_pkg::ID_W-1:0]   dst_inst,
    input  logic [ttt_pkg::ADDR_W-1:0] src_address,
    input  logic [ttt_pkg::OFF_W-1:0]  src_field_offset,
    input  logic [ttt_pkg::ADDR_W-1:0] dst_address,
    input  logic [ttt_pkg::OFF_W-1:0]  dst_field_offset,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       tainted,
    output logic                       overflow
);

    ttt_pkg::ctrl_cmd_t  cmd;
    ttt_pkg::dp_status_t status;

    ttt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ttt_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .mode             (mode),
        .src_inst         (src_inst),
        .dst_inst         (dst_inst),
        .src_address      (src_address),
        .src_field_offset (src_field_offset),
        .dst_address      (dst_address),
        .dst_field_offset (dst_field_offset),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .tainted          (tainted),
        .overflow         (overflow)
    );

endmodule

@@ verif/taint_tag_table_unit_test.sv @@
// Self-checking testbench for the taint tag table with a built-in taint predictor.
module taint_tag_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int ID_POOL        = 24;
    localparam int PAIR_POOL      = 80;
    localparam int FILL_PAIRS     = ttt_pkg::ADDR_ENTRIES + 6;

    localparam logic [ttt_pkg::MODE_W-1:0] MODE_NOP_FIRST = ttt_pkg::MODE_M2M + 1'b1;
    localparam logic [ttt_pkg::MODE_W-1:0] MODE_NOP_LAST  = '1;

    typedef struct {
        logic [ttt_pkg::MODE_W-1:0] mode;
        logic [ttt_pkg::ID_W-1:0]   src_inst;
        logic [ttt_pkg::ID_W-1:0]   dst_inst;
        logic [ttt_pkg::ADDR_W-1:0] src_address;
        logic [ttt_pkg::OFF_W-1:0]  src_field_offset;
        logic [ttt_pkg::ADDR_W-1:0] dst_address;
        logic [ttt_pkg::OFF_W-1:0]  dst_field_offset;
    } taint_op_t;

    typedef struct {
        logic tainted;
        logic overflow;
    } taint_verdict_t;

    logic                       clk;
    logic                       rst_n            = 1'b0;
    logic                       in_valid         = 1'b0;
    logic                       in_stall;
    logic [ttt_pkg::MODE_W-1:0] mode             = '0;
    logic [ttt_pkg::ID_W-1:0]   src_inst         = '0;
    logic [ttt_pkg::ID_W-1:0]   dst_inst         = '0;
    logic [ttt_pkg::ADDR_W-1:0] src_address      = '0;
    logic [ttt_pkg::OFF_W-1:0]  src_field_offset = '0;
    logic [ttt_pkg::ADDR_W-1:0] dst_address      = '0;
    logic [ttt_pkg::OFF_W-1:0]  dst_field_offset = '0;
    logic                       out_valid;
    logic                       out_stall        = 1'b0;
    logic                       tainted;
    logic                       overflow;

    logic                       inst_taint [ttt_pkg::INST_IDS]     = '{default: 1'b0};
    logic                       pair_live  [ttt_pkg::ADDR_ENTRIES] = '{default: 1'b0};
    logic [ttt_pkg::ADDR_W-1:0] pair_addr  [ttt_pkg::ADDR_ENTRIES];
    logic [ttt_pkg::OFF_W-1:0]  pair_off   [ttt_pkg::ADDR_ENTRIES];

    logic [ttt_pkg::ID_W-1:0]   id_pool        [ID_POOL];
    logic [ttt_pkg::ADDR_W-1:0] pool_addr      [PAIR_POOL];
    logic [ttt_pkg::OFF_W-1:0]  pool_off       [PAIR_POOL];

    taint_verdict_t    pending_verdicts [$];
    int                mismatch_count = 0;
    int                stuck_cycles   = 0;
    int                send_idle_pct  = 0;
    int                recv_idle_pct  = 0;
    int                hold_requests  = 0;
    int                hold_served    = 0;
    int                hold_left      = 0;

    taint_tag_table_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .src_inst         (src_inst),
        .dst_inst         (dst_inst),
        .src_address      (src_address),
        .src_field_offset (src_field_offset),
        .dst_address      (dst_address),
        .dst_field_offset (dst_field_offset),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .tainted          (tainted),
        .overflow         (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pair_lookup(logic [ttt_pkg::ADDR_W-1:0] addr,
                                       logic [ttt_pkg::OFF_W-1:0] off);
        for (int i = 0; i < ttt_pkg::ADDR_ENTRIES; i++)
        begin
            if (pair_live[i] && pair_addr[i] == addr && pair_off[i] == off)
                return i;
        end
        return -1;
    endfunction

    function automatic logic pair_insert(logic [ttt_pkg::ADDR_W-1:0] addr,
                                         logic [ttt_pkg::OFF_W-1:0] off);
        if (pair_lookup(addr, off) >= 0)
            return 1'b0;
        for (int i = 0; i < ttt_pkg::ADDR_ENTRIES; i++)
        begin
            if (!pair_live[i])
            begin
                pair_live[i] = 1'b1;
                pair_addr[i] = addr;
                pair_off[i]  = off;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void pair_drop(logic [ttt_pkg::ADDR_W-1:0] addr,
                                      logic [ttt_pkg::OFF_W-1:0] off);
        int idx;
        idx = pair_lookup(addr, off);
        if (idx >= 0)
            pair_live[idx] = 1'b0;
    endfunction

    function automatic taint_verdict_t predict_taint(taint_op_t op);
        taint_verdict_t v;
        v.tainted  = 1'b0;
        v.overflow = 1'b0;
        case (op.mode)
            ttt_pkg::MODE_QINST:
                v.tainted = inst_taint[op.src_inst];
            ttt_pkg::MODE_QADDR:
                v.tainted = pair_lookup(op.src_address, op.src_field_offset) >= 0;
            ttt_pkg::MODE_MARKINST:
            begin
                v.tainted = inst_taint[op.src_inst];
                inst_taint[op.src_inst] = 1'b1;
            end
            ttt_pkg::MODE_MARKADDR:
            begin
                v.tainted  = pair_lookup(op.src_address, op.src_field_offset) >= 0;
                v.overflow = pair_insert(op.src_address, op.src_field_offset);
            end
            ttt_pkg::MODE_RMINST:
            begin
                v.tainted = inst_taint[op.src_inst];
                inst_taint[op.src_inst] = 1'b0;
            end
            ttt_pkg::MODE_RMADDR:
            begin
                v.tainted = pair_lookup(op.src_address, op.src_field_offset) >= 0;
                pair_drop(op.src_address, op.src_field_offset);
            end
            ttt_pkg::MODE_R2R:
            begin
                v.tainted = inst_taint[op.src_inst];
                if (v.tainted)
                    inst_taint[op.dst_inst] = 1'b1;
            end
            ttt_pkg::MODE_R2M:
            begin
                v.tainted = inst_taint[op.src_inst];
                if (v.tainted)
                    v.overflow = pair_insert(op.dst_address, op.dst_field_offset);
            end
            ttt_pkg::MODE_M2R:
            begin
                v.tainted = pair_lookup(op.src_address, op.src_field_offset) >= 0;
                if (v.tainted)
                    inst_taint[op.dst_inst] = 1'b1;
            end
            ttt_pkg::MODE_M2M:
            begin
                v.tainted = pair_lookup(op.src_address, op.src_field_offset) >= 0;
                if (v.tainted)
                    v.overflow = pair_insert(op.dst_address, op.dst_field_offset);
                else
                    pair_drop(op.dst_address, op.dst_field_offset);
            end
            default:
                ;
        endcase
        return v;
    endfunction

    function automatic taint_op_t build_op(logic [ttt_pkg::MODE_W-1:0] m,
                                           logic [ttt_pkg::ID_W-1:0]   si,
                                           logic [ttt_pkg::ID_W-1:0]   di,
                                           logic [ttt_pkg::ADDR_W-1:0] sa,
                                           logic [ttt_pkg::OFF_W-1:0]  so,
                                           logic [ttt_pkg::ADDR_W-1:0] da,
                                           logic [ttt_pkg::OFF_W-1:0]  dof);
        taint_op_t op;
        op.mode             = m;
        op.src_inst         = si;
        op.dst_inst         = di;
        op.src_address      = sa;
        op.src_field_offset = so;
        op.dst_address      = da;
        op.dst_field_offset = dof;
        return op;
    endfunction

    function automatic logic [ttt_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(99) < 75)
            return id_pool[$urandom_range(ID_POOL - 1)];
        return ttt_pkg::ID_W'($urandom);
    endfunction

    function automatic void pick_pair(output logic [ttt_pkg::ADDR_W-1:0] addr,
                                      output logic [ttt_pkg::OFF_W-1:0] off);
        int k;
        if ($urandom_range(99) < 85)
        begin
            k    = $urandom_range(PAIR_POOL - 1);
            addr = pool_addr[k];
            off  = pool_off[k];
        end
        else
        begin
            addr = {$urandom, $urandom};
            off  = $urandom;
        end
    endfunction

    function automatic taint_op_t random_op();
        taint_op_t op;
        int        r;
        r = $urandom_range(99);
        if (r < 6)
            op.mode = ttt_pkg::MODE_QINST;
        else if (r < 14)
            op.mode = ttt_pkg::MODE_QADDR;
        else if (r < 22)
            op.mode = ttt_pkg::MODE_MARKINST;
        else if (r < 40)
            op.mode = ttt_pkg::MODE_MARKADDR;
        else if (r < 46)
            op.mode = ttt_pkg::MODE_RMINST;
        else if (r < 54)
            op.mode = ttt_pkg::MODE_RMADDR;
        else if (r < 62)
            op.mode = ttt_pkg::MODE_R2R;
        else if (r < 72)
            op.mode = ttt_pkg::MODE_R2M;
        else if (r < 80)
            op.mode = ttt_pkg::MODE_M2R;
        else if (r < 94)
            op.mode = ttt_pkg::MODE_M2M;
        else
            op.mode = ttt_pkg::MODE_W'($urandom_range(MODE_NOP_LAST, MODE_NOP_FIRST));
        op.src_inst = pick_id();
        op.dst_inst = pick_id();
        pick_pair(op.src_address, op.src_field_offset);
        pick_pair(op.dst_address, op.dst_field_offset);
        return op;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_op(input taint_op_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        mode             <= op.mode;
        src_inst         <= op.src_inst;
        dst_inst         <= op.dst_inst;
        src_address      <= op.src_address;
        src_field_offset <= op.src_field_offset;
        dst_address      <= op.dst_address;
        dst_field_offset <= op.dst_field_offset;
        do
            @(posedge clk);
        while (in_stall);
        pending_verdicts.push_back(predict_taint(op));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic test_instruction_ids();
        send_op(build_op(ttt_pkg::MODE_QINST, '0, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_MARKINST, '0, '1, '1, '1, '1, '1));
        send_op(build_op(ttt_pkg::MODE_MARKINST, '1, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_MARKINST, '1, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_QINST, '1, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_R2R, '0, 12'h555, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_R2R, 12'h0AA, 12'h0AB, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_QINST, 12'h555, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_QINST, 12'h0AB, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_RMINST, '1, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_RMINST, '1, '0, '0, '0, '0, '0));
    endtask

    task automatic test_address_pairs();
        send_op(build_op(ttt_pkg::MODE_QADDR, '0, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_MARKADDR, '0, '0, '0, '0, '1, '1));
        send_op(build_op(ttt_pkg::MODE_MARKADDR, '0, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_MARKADDR, '1, '1, '1, '1, '0, '0));
        send_op(build_op(ttt_pkg::MODE_QADDR, '0, '0, '1, '1, '0, '0));
        send_op(build_op(ttt_pkg::MODE_QADDR, '0, '0, '1, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_RMADDR, '0, '0, '1, '1, '0, '0));
        send_op(build_op(ttt_pkg::MODE_RMADDR, '0, '0, '1, '1, '0, '0));
        send_op(build_op(ttt_pkg::MODE_R2M, '0, '0, '0, '0,
                         64'hDEAD_BEEF_0123_4567, 32'h89AB_CDEF));
        send_op(build_op(ttt_pkg::MODE_R2M, 12'h0AA, '0, '0, '0, 64'h1, 32'h2));
        send_op(build_op(ttt_pkg::MODE_QADDR, '0, '0, 64'h1, 32'h2, '0, '0));
        send_op(build_op(ttt_pkg::MODE_M2R, '0, 12'h123, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_M2R, '0, 12'h124, 64'h1, 32'h2, '0, '0));
        send_op(build_op(ttt_pkg::MODE_QINST, 12'h123, '0, '0, '0, '0, '0));
        send_op(build_op(ttt_pkg::MODE_M2M, '0, '0, '0, '0, 64'hFACE, 32'h7));
        send_op(build_op(ttt_pkg::MODE_M2M, '0, '0, 64'h1, 32'h2, 64'hFACE, 32'h7));
        send_op(build_op(ttt_pkg::MODE_QADDR, '0, '0, 64'hFACE, 32'h7, '0, '0));
    endtask

    task automatic test_unused_modes();
        for (int m = MODE_NOP_FIRST; m <= MODE_NOP_LAST; m++)
            send_op(build_op(ttt_pkg::MODE_W'(m), '1, '1, '1, '1, '1, '1));
    endtask

    task automatic test_table_full();
        logic [ttt_pkg::ADDR_W-1:0] fill_addr [FILL_PAIRS];
        logic [ttt_pkg::OFF_W-1:0]  fill_off  [FILL_PAIRS];
        logic [ttt_pkg::ADDR_W-1:0] spare_addr;
        logic [ttt_pkg::OFF_W-1:0]  spare_off;
        for (int i = 0; i < FILL_PAIRS; i++)
        begin
            fill_addr[i] = {$urandom, $urandom};
            fill_off[i]  = $urandom;
            send_op(build_op(ttt_pkg::MODE_MARKADDR, '0, '0, fill_addr[i], fill_off[i], '0, '0));
        end
        send_op(build_op(ttt_pkg::MODE_R2M, '0, '0, '0, '0, {$urandom, $urandom}, $urandom));
        send_op(build_op(ttt_pkg::MODE_M2M, '0, '0, '0, '0, {$urandom, $urandom}, $urandom));
        send_op(build_op(ttt_pkg::MODE_RMADDR, '0, '0, fill_addr[0], fill_off[0], '0, '0));
        spare_addr = {$urandom, $urandom};
        spare_off  = $urandom;
        send_op(build_op(ttt_pkg::MODE_MARKADDR, '0, '0, spare_addr, spare_off, '0, '0));
        send_op(build_op(ttt_pkg::MODE_RMADDR, '0, '0, spare_addr, spare_off, '0, '0));
        for (int i = 1; i < FILL_PAIRS; i++)
            send_op(build_op(ttt_pkg::MODE_RMADDR, '0, '0, fill_addr[i], fill_off[i], '0, '0));
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_op(random_op());
    endtask

    task automatic test_backpressure();
        int saved_send_pct;
        saved_send_pct = send_idle_pct;
        send_idle_pct  = 0;
        hold_requests++;
        repeat (30)
            send_op(random_op());
        wait_drained();
        repeat (10)
            send_op(random_op());
        send_idle_pct = saved_send_pct;
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t ns: unexpected transaction, expected none, %s %0b overflow %0b",
                         $realtime, "got tainted", tainted, overflow);
                mismatch_count++;
            end
            else
            begin
                if (tainted !== pending_verdicts[0].tainted)
                begin
                    $display("%0t ns: tainted mismatch, expected %0b, got %0b",
                             $realtime, pending_verdicts[0].tainted, tainted);
                    mismatch_count++;
                end
                if (overflow !== pending_verdicts[0].overflow)
                begin
                    $display("%0t ns: overflow mismatch, expected %0b, got %0b",
                             $realtime, pending_verdicts[0].overflow, overflow);
                    mismatch_count++;
                end
                void'(pending_verdicts.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL; i++)
            id_pool[i] = ttt_pkg::ID_W'($urandom);
        pool_addr[0] = '0;
        pool_off[0]  = '0;
        pool_addr[1] = '1;
        pool_off[1]  = '1;
        for (int i = 2; i < PAIR_POOL; i++)
        begin
            if (i[0] && $urandom_range(1))
                pool_addr[i] = pool_addr[i-1];
            else
                pool_addr[i] = {$urandom, $urandom};
            pool_off[i] = $urandom;
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 58;
        test_instruction_ids();
        test_address_pairs();
        test_unused_modes();
        test_table_full();
        test_random_traffic(330, 36, 58);
        test_backpressure();
        test_random_traffic(330, 58, 36);
        test_random_traffic(330, 0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
